/* design/bda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the button debounce and auto-repeat block.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CountW  = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [MsW-1:0] DebounceReset   = MsW'(100);
  localparam logic [MsW-1:0] RepeatReset     = '0;
  localparam logic [MsW-1:0] StartDelayReset = '0;
  localparam logic           OffLevelReset   = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE    = 2'd0,
    CFG_REPEAT      = 2'd1,
    CFG_START_DELAY = 2'd2,
    CFG_OFF_LEVEL   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] repeat_ms;
    logic [MsW-1:0] start_delay_ms;
    logic           off_level;
  } bda_cfg_t;

  typedef struct packed {
    logic             accepted_level;
    logic [TimeW-1:0] last_change_time;
    logic             press_active;
    logic [TimeW-1:0] press_start_time;
    logic [TimeW-1:0] last_repeat_time;
  } bda_state_t;

  typedef struct packed {
    logic              key_down;
    logic              key_up;
    logic [CountW-1:0] key_press_count;
    logic              is_pressed;
    logic [TimeW-1:0]  press_time_ms;
  } bda_result_t;

endpackage

/* design/bda_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_eval
// Evaluates one poll: debounce decision, press/release, repeat, next state.
// ----------------------------------------------------------------------------
module bda_eval
  import bda_pkg::*;
(
  input  bda_cfg_t         cfg_i,
  input  bda_state_t       state_i,
  input  logic             pin_level_i,
  input  logic [TimeW-1:0] now_ms_i,
  output bda_state_t       state_o,
  output bda_result_t      result_o
);

  logic [TimeW-1:0]  since_change;
  logic [TimeW-1:0]  since_start;
  logic [TimeW-1:0]  since_repeat;
  logic [TimeW-1:0]  start_eff;
  logic              accept;
  logic              newly_pressed;
  logic              delay_done;
  logic              repeat_due;
  logic [CountW-1:0] presses;

  assign since_change = now_ms_i - state_i.last_change_time;
  assign since_repeat = now_ms_i - state_i.last_repeat_time;

  // A fresh press restarts the hold time at zero.
  assign newly_pressed = !state_i.press_active;
  assign start_eff     = newly_pressed ? now_ms_i : state_i.press_start_time;
  assign since_start   = newly_pressed ? '0 : (now_ms_i - state_i.press_start_time);

  assign accept = (pin_level_i == state_i.accepted_level) ||
                  (since_change >= TimeW'(cfg_i.debounce_ms));

  assign delay_done = since_start >= TimeW'(cfg_i.start_delay_ms);
  assign repeat_due = since_repeat >= TimeW'(cfg_i.repeat_ms);

  always_comb begin
    state_o  = state_i;
    presses  = '0;
    result_o = '0;
    if (pin_level_i != state_i.accepted_level && accept) begin
      state_o.last_change_time = now_ms_i;
      state_o.accepted_level   = pin_level_i;
    end
    if (accept) begin
      if (pin_level_i == cfg_i.off_level) begin
        result_o.key_up          = state_i.press_active;
        state_o.press_active     = 1'b0;
        state_o.press_start_time = '0;
        state_o.last_repeat_time = '0;
      end else begin
        if (newly_pressed) begin
          state_o.press_active     = 1'b1;
          state_o.press_start_time = now_ms_i;
          result_o.key_down        = 1'b1;
          presses                  = CountW'(1);
        end
        if (cfg_i.repeat_ms != '0) begin
          if (!delay_done) begin
            state_o.last_repeat_time = now_ms_i;
          end else if (repeat_due) begin
            state_o.last_repeat_time = now_ms_i;
            presses                  = presses + CountW'(1);
          end
        end
      end
    end
    result_o.key_press_count = presses;
    result_o.is_pressed      = state_o.press_active;
    result_o.press_time_ms   = state_o.press_active ? (now_ms_i - start_eff) : '0;
  end

endmodule

/* design/button_debounce_autorepeat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Push-button debounce with auto-repeat key-press events, one poll per word.
// ----------------------------------------------------------------------------
// Path: an accepted input word is held in the input register; its result is
// captured in the result register and offered on the output stream.
// Throughput: one poll per clock; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst_ni low, asynchronous): the configuration and state registers return to
// their reset values, the button counts as released and both stages are empty.
module button_debounce_autorepeat
  import bda_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [MsW-1:0]      cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] key_down, [1] key_up, [3:2] key_press_count, [4] is_pressed,
  // [36:5] press_time_ms, [39:37] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  bda_cfg_t         cfg_q;
  bda_state_t       state_q, state_d, eval_state;
  bda_result_t      result_d, result_q;
  logic             in_valid_q, out_valid_q;
  logic             in_level_q;
  logic [TimeW-1:0] in_now_q;
  logic             advance;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  bda_eval u_eval (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .pin_level_i (in_level_q),
    .now_ms_i    (in_now_q),
    .state_o     (eval_state),
    .result_o    (result_d)
  );

  // Writing the released level also moves the accepted level with it.
  always_comb begin
    state_d = state_q;
    if (in_valid_q && advance) begin
      state_d = eval_state;
    end
    if (cfg_we_i && (cfg_idx_e'(cfg_addr_i) == CFG_OFF_LEVEL)) begin
      state_d.accepted_level = cfg_wdata_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms    <= DebounceReset;
      cfg_q.repeat_ms      <= RepeatReset;
      cfg_q.start_delay_ms <= StartDelayReset;
      cfg_q.off_level      <= OffLevelReset;
      state_q              <= {OffLevelReset, TimeW'(0), 1'b0, TimeW'(0), TimeW'(0)};
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_DEBOUNCE:    cfg_q.debounce_ms    <= cfg_wdata_i;
          CFG_REPEAT:      cfg_q.repeat_ms      <= cfg_wdata_i;
          CFG_START_DELAY: cfg_q.start_delay_ms <= cfg_wdata_i;
          CFG_OFF_LEVEL:   cfg_q.off_level      <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level_q <= s_axis_tdata[0];
      in_now_q   <= s_axis_tdata[TimeW:1];
    end
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - 5 - TimeW)'(0), result_q.press_time_ms,
                          result_q.is_pressed, result_q.key_press_count,
                          result_q.key_up, result_q.key_down};

  // Key-down and key-up are never reported in the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(result_q.key_down && result_q.key_up))
    else $error("key_down and key_up in one word");

  // Any key-press event implies the button is held after the poll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result_q.key_press_count != '0) |-> result_q.is_pressed)
    else $error("key press reported while released");

  // A reported release leaves the press state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result_q.key_up) |-> !state_q.press_active)
    else $error("press still active after key_up");

  // The state register only moves when a poll is evaluated or configuration is written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(in_valid_q && advance) && !$past(cfg_we_i)) |-> $stable(state_q))
    else $error("state changed without a poll");

endmodule

/* tb/sv/bda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_checker
// Watches the register port and both streams of the debounce block. It keeps
// its own copy of the button state, predicts one result word per poll word
// and compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bda_checker
  import bda_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [MsW-1:0]      cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  // [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  // [0] key_down, [1] key_up, [3:2] key_press_count, [4] is_pressed,
  // [36:5] press_time_ms, [39:37] zero
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);

  bda_cfg_t    cfg_q;
  bda_state_t  btn_q;
  bda_result_t pending_events[$];
  int          event_mismatches;
  int          results_seen;

  // Advances the button state by one poll and returns the events it fires.
  function automatic bda_result_t poll_button(input logic level,
                                              input logic [TimeW-1:0] now);
    bda_result_t      res;
    logic             accept;
    logic [TimeW-1:0] since_change;
    logic [TimeW-1:0] since_start;
    logic [TimeW-1:0] since_repeat;
    res          = '0;
    accept       = 1'b1;
    since_change = now - btn_q.last_change_time;
    if (level != btn_q.accepted_level) begin
      if (since_change < TimeW'(cfg_q.debounce_ms)) begin
        accept = 1'b0;
      end else begin
        btn_q.last_change_time = now;
        btn_q.accepted_level   = level;
      end
    end
    if (accept) begin
      if (level == cfg_q.off_level) begin
        res.key_up             = btn_q.press_active;
        btn_q.press_active     = 1'b0;
        btn_q.press_start_time = '0;
        btn_q.last_repeat_time = '0;
      end else begin
        if (!btn_q.press_active) begin
          btn_q.press_active     = 1'b1;
          btn_q.press_start_time = now;
          res.key_down           = 1'b1;
          res.key_press_count    = CountW'(1);
        end
        if (cfg_q.repeat_ms != '0) begin
          since_start  = now - btn_q.press_start_time;
          since_repeat = now - btn_q.last_repeat_time;
          // Until the start delay has run out the repeat timer tracks the
          // current time, so the first repeat comes one interval later.
          if (since_start >= TimeW'(cfg_q.start_delay_ms)) begin
            if (since_repeat >= TimeW'(cfg_q.repeat_ms)) begin
              btn_q.last_repeat_time = now;
              res.key_press_count    = res.key_press_count + CountW'(1);
            end
          end else begin
            btn_q.last_repeat_time = now;
          end
        end
      end
    end
    res.is_pressed    = btn_q.press_active;
    res.press_time_ms = btn_q.press_active ? now - btn_q.press_start_time : '0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bda_result_t exp_ev;
    bda_result_t got_ev;
    if (!rst_ni) begin
      cfg_q.debounce_ms      = DebounceReset;
      cfg_q.repeat_ms        = RepeatReset;
      cfg_q.start_delay_ms   = StartDelayReset;
      cfg_q.off_level        = OffLevelReset;
      btn_q.accepted_level   = OffLevelReset;
      btn_q.last_change_time = '0;
      btn_q.press_active     = 1'b0;
      btn_q.press_start_time = '0;
      btn_q.last_repeat_time = '0;
      pending_events.delete();
      event_mismatches = 0;
      results_seen     = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_DEBOUNCE:    cfg_q.debounce_ms    = cfg_wdata_i;
          CFG_REPEAT:      cfg_q.repeat_ms      = cfg_wdata_i;
          CFG_START_DELAY: cfg_q.start_delay_ms = cfg_wdata_i;
          CFG_OFF_LEVEL: begin
            cfg_q.off_level      = cfg_wdata_i[0];
            btn_q.accepted_level = cfg_wdata_i[0];
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_events.push_back(poll_button(s_axis_tdata_i[0],
                                             s_axis_tdata_i[TimeW:1]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_ev.key_down        = m_axis_tdata_i[0];
        got_ev.key_up          = m_axis_tdata_i[1];
        got_ev.key_press_count = m_axis_tdata_i[3:2];
        got_ev.is_pressed      = m_axis_tdata_i[4];
        got_ev.press_time_ms   = m_axis_tdata_i[TimeW+4:5];
        if (pending_events.size() == 0) begin
          if (event_mismatches < 10) begin
            $display("bda_checker: result word %0d arrived with no poll waiting",
                     results_seen);
          end
          event_mismatches++;
        end else begin
          exp_ev = pending_events.pop_front();
          if (got_ev.key_down != exp_ev.key_down ||
              got_ev.key_up != exp_ev.key_up ||
              got_ev.key_press_count != exp_ev.key_press_count ||
              got_ev.is_pressed != exp_ev.is_pressed ||
              got_ev.press_time_ms != exp_ev.press_time_ms) begin
            if (event_mismatches < 10) begin
              $display("bda_checker: result word %0d: expected down=%0d up=%0d presses=%0d pressed=%0d time=%0d",
                       results_seen, exp_ev.key_down, exp_ev.key_up,
                       exp_ev.key_press_count, exp_ev.is_pressed,
                       exp_ev.press_time_ms);
              $display("bda_checker: result word %0d:   actual down=%0d up=%0d presses=%0d pressed=%0d time=%0d",
                       results_seen, got_ev.key_down, got_ev.key_up,
                       got_ev.key_press_count, got_ev.is_pressed,
                       got_ev.press_time_ms);
            end
            event_mismatches++;
          end
        end
        results_seen++;
      end
      mismatch_count_o <= event_mismatches;
      pending_o        <= pending_events.size();
    end
  end

endmodule

/* tb/sv/tb_button_debounce_autorepeat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_autorepeat
// Drives button polls into the debounce block: a directed sequence over the
// register extremes, then random press, bounce, hold and release sequences
// under several register settings and several idle patterns on both streams.
// ----------------------------------------------------------------------------
module tb_button_debounce_autorepeat;
  import bda_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i    = CFG_DEBOUNCE;
  logic [MsW-1:0]      cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int mismatch_count;
  int pending_polls;

  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          stall_epoch  = 0;
  int          rx_epoch     = 0;
  int          rx_hold_left = 0;
  int          polls_sent   = 0;
  logic [31:0] now_ms       = '0;
  bda_cfg_t    cur_cfg;

  button_debounce_autorepeat i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bda_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_polls)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off per stall request.
  always @(posedge clk_i) begin
    if (stall_epoch != rx_epoch) begin
      rx_epoch     = stall_epoch;
      rx_hold_left = 120;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic poll(input logic level, input logic [31:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-TimeW-1){1'b0}}, t, level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    polls_sent++;
  endtask

  // The pending count is registered, so the first wait covers the last word.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_polls != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [MsW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [MsW-1:0] debounce, input logic [MsW-1:0] rep,
                            input logic [MsW-1:0] delay, input logic off);
    drain();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_REPEAT, rep);
    write_reg(CFG_START_DELAY, delay);
    write_reg(CFG_OFF_LEVEL, MsW'(off));
    cur_cfg.debounce_ms    = debounce;
    cur_cfg.repeat_ms      = rep;
    cur_cfg.start_delay_ms = delay;
    cur_cfg.off_level      = off;
  endtask

  function automatic logic [MsW-1:0] pick_ms();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return MsW'($urandom_range(0, 65535));
      default: return MsW'($urandom_range(1, 30));
    endcase
  endfunction

  function automatic logic [31:0] hold_step();
    int span;
    span = (cur_cfg.repeat_ms > cur_cfg.start_delay_ms) ? int'(cur_cfg.repeat_ms)
                                                        : int'(cur_cfg.start_delay_ms);
    span = span / 4 + 2;
    if ($urandom_range(3) == 0) return 32'(cur_cfg.repeat_ms);
    return 32'($urandom_range(0, span));
  endfunction

  // Quick flips around a level change; most fall inside the debounce window.
  task automatic bounce(input logic settled);
    repeat ($urandom_range(0, 3)) begin
      now_ms += $urandom_range(0, 3);
      poll(~settled, now_ms);
      now_ms += $urandom_range(0, 2);
      poll(settled, now_ms);
    end
  endtask

  task automatic press_episode(input bit with_release);
    logic on_lvl;
    on_lvl = ~cur_cfg.off_level;
    repeat ($urandom_range(0, 2)) begin
      now_ms += $urandom_range(0, 5);
      poll(cur_cfg.off_level, now_ms);
    end
    now_ms += 32'(cur_cfg.debounce_ms) + $urandom_range(0, 3);
    poll(on_lvl, now_ms);
    bounce(on_lvl);
    repeat ($urandom_range(1, 12)) begin
      now_ms += hold_step();
      poll(on_lvl, now_ms);
    end
    if (with_release) begin
      now_ms += 32'(cur_cfg.debounce_ms) + $urandom_range(0, 3);
      poll(cur_cfg.off_level, now_ms);
      bounce(cur_cfg.off_level);
    end
  endtask

  task automatic random_stretch();
    case ($urandom_range(9))
      0: begin
        now_ms += $urandom_range(0, 50);
        poll(1'($urandom_range(0, 1)), now_ms);
      end
      1: begin
        now_ms = $urandom();
        press_episode(1'b1);
      end
      2: begin
        now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        press_episode(1'b1);
      end
      3: press_episode(1'b0);
      default: press_episode(1'b1);
    endcase
  endtask

  initial begin
    int  phase_end;
    bit  paused;
    cur_cfg.debounce_ms    = DebounceReset;
    cur_cfg.repeat_ms      = RepeatReset;
    cur_cfg.start_delay_ms = StartDelayReset;
    cur_cfg.off_level      = OffLevelReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings after reset: press at the debounce boundary, a rejected
    // release, then the real release.
    poll(1'b0, 32'd0);
    poll(1'b1, 32'd50);
    poll(1'b1, 32'd100);
    poll(1'b1, 32'd150);
    poll(1'b0, 32'd199);
    poll(1'b0, 32'd200);
    poll(1'b0, 32'hFFFF_FFFF);

    // Inverted pin, no debounce: the first press poll also fires a repeat,
    // and the press time runs across the wrap of the clock.
    set_config('0, MsW'(10), '0, 1'b1);
    poll(1'b0, 32'hFFFF_FFF0);
    poll(1'b0, 32'hFFFF_FFFA);
    poll(1'b0, 32'h0000_0004);
    poll(1'b0, 32'h0000_0005);
    poll(1'b1, 32'h0000_0006);

    // All intervals at their maximum.
    set_config('1, '1, '1, 1'b0);
    poll(1'b1, 32'h0001_0000);
    poll(1'b1, 32'h0001_0005);
    poll(1'b1, 32'h0002_0004);
    poll(1'b0, 32'h0002_0005);

    // Short start delay: the repeat timer follows the clock until it passes.
    set_config(MsW'(5), MsW'(1), MsW'(3), 1'b0);
    poll(1'b1, 32'h0003_0000);
    poll(1'b1, 32'h0003_0001);
    poll(1'b1, 32'h0003_0002);
    poll(1'b1, 32'h0003_0003);
    poll(1'b1, 32'h0003_0004);
    poll(1'b0, 32'h0003_0004);
    poll(1'b0, 32'h0003_0005);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        set_config(pick_ms(), pick_ms(), pick_ms(), 1'($urandom_range(0, 1)));
        phase_end = polls_sent + 125;
        paused    = 1'b0;
        if (k == 1) stall_epoch++;
        while (polls_sent < phase_end) begin
          random_stretch();
          if (k == 2 && !paused && polls_sent >= phase_end - 60) begin
            drain();
            paused = 1'b1;
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_polls != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/bda_pkg.sv
design/bda_eval.sv
design/button_debounce_autorepeat.sv
tb/sv/bda_checker.sv
tb/sv/tb_button_debounce_autorepeat.sv
